// ===== rtl/debounced_key_event_logger_assert.svh =====
// assertion macros used by the key event logger top level
`ifndef DEBOUNCED_KEY_EVENT_LOGGER_ASSERT_SVH
`define DEBOUNCED_KEY_EVENT_LOGGER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DKEL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("dkel assertion failed");

// next-cycle implication, checked outside reset
`define DKEL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("dkel assertion failed");

`endif

// ===== rtl/dkel_pkg.sv =====
// shared types and constants of the key event logger
package dkel_pkg;

  // action codes of an input item
  localparam logic [1:0] ACT_SAMPLE  = 2'd0;
  localparam logic [1:0] ACT_SEED    = 2'd1;
  localparam logic [1:0] ACT_RESTORE = 2'd2;

  localparam logic [7:0] HIST_ALL_HIGH = 8'hFF;
  localparam logic [7:0] HIST_ALL_LOW  = 8'h00;
  localparam logic [7:0] LOG_ERASED    = 8'hFF;

  typedef struct packed {
    logic [1:0] action;
    logic       key_level;
    logic [7:0] log_byte;
  } dkel_in_t;

  typedef struct packed {
    logic        event_valid;
    logic        event_value;
    logic        led_level;
    logic        erase_first;
    logic [11:0] write_offset;
    logic [3:0]  record_count;
    logic [9:0]  record_bits;
  } dkel_out_t;

endpackage

// ===== rtl/dkel_in_stage.sv =====
// input register stage with valid/ready handshake
module dkel_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dkel_pkg::dkel_in_t in_data_i,
  input  logic             take_i,
  output logic             valid_o,
  output dkel_pkg::dkel_in_t data_o
);

  logic               valid_q, valid_d;
  dkel_pkg::dkel_in_t data_q;
  logic               in_fire;

  assign in_ready_o = !valid_q || take_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (in_fire) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/dkel_step.sv =====
// next-state and result logic for one item
module dkel_step #(
  parameter int RECORD_DEPTH = 10,
  parameter int LOG_SIZE     = 4096,
  localparam int OW = $clog2(LOG_SIZE + 1),
  localparam int CW = $clog2(RECORD_DEPTH + 1)
) (
  input  dkel_pkg::dkel_in_t  item_i,
  input  logic [7:0]          hist_i,
  input  logic                stable_i,
  input  logic [RECORD_DEPTH-1:0] win_i,
  input  logic [CW-1:0]       cnt_i,
  input  logic [OW-1:0]       log_i,
  input  logic [OW-1:0]       pos_i,
  input  logic                scan_i,
  output logic [7:0]          hist_o,
  output logic                stable_o,
  output logic [RECORD_DEPTH-1:0] win_o,
  output logic [CW-1:0]       cnt_o,
  output logic [OW-1:0]       log_o,
  output logic [OW-1:0]       pos_o,
  output logic                scan_o,
  output dkel_pkg::dkel_out_t res_o
);

  logic [7:0]    hist_sh;
  logic          ev_valid, ev_value, erase, push, push_val;
  logic [OW-1:0] woff, base;

  always_comb begin
    hist_o   = hist_i;
    stable_o = stable_i;
    log_o    = log_i;
    pos_o    = pos_i;
    scan_o   = scan_i;
    ev_valid = 1'b0;
    ev_value = 1'b0;
    erase    = 1'b0;
    woff     = '0;
    push     = 1'b0;
    push_val = 1'b0;
    hist_sh  = {hist_i[6:0], item_i.key_level};
    base     = log_i;

    case (item_i.action)
      dkel_pkg::ACT_SAMPLE: begin
        scan_o = 1'b0;
        hist_o = hist_sh;
        if (hist_sh == dkel_pkg::HIST_ALL_LOW && stable_i) begin
          stable_o = 1'b0;
          ev_valid = 1'b1;
          ev_value = 1'b1;
        end else if (hist_sh == dkel_pkg::HIST_ALL_HIGH && !stable_i) begin
          stable_o = 1'b1;
          ev_valid = 1'b1;
          ev_value = 1'b0;
        end
        if (ev_valid) begin
          // full log wraps to the start after an erase
          if (log_i >= OW'(LOG_SIZE)) begin
            erase = 1'b1;
            base  = '0;
          end
          woff     = base;
          log_o    = base + OW'(1);
          push     = 1'b1;
          push_val = ev_value;
        end
      end
      dkel_pkg::ACT_SEED: begin
        stable_o = item_i.key_level;
        hist_o   = item_i.key_level ? dkel_pkg::HIST_ALL_HIGH : dkel_pkg::HIST_ALL_LOW;
      end
      dkel_pkg::ACT_RESTORE: begin
        if (scan_i) begin
          if (item_i.log_byte == dkel_pkg::LOG_ERASED) begin
            log_o  = pos_i;
            scan_o = 1'b0;
          end else begin
            push     = (item_i.log_byte[7:1] == 7'd0);
            push_val = item_i.log_byte[0];
            pos_o    = pos_i + OW'(1);
            if (pos_i + OW'(1) >= OW'(LOG_SIZE)) begin
              scan_o = 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // recent event window: fill upward, then slide down
  always_comb begin
    win_o = win_i;
    cnt_o = cnt_i;
    if (push) begin
      if (cnt_i < CW'(RECORD_DEPTH)) begin
        for (int i = 0; i < RECORD_DEPTH; i++) begin
          if (cnt_i == CW'(i)) begin
            win_o[i] = push_val;
          end
        end
        cnt_o = cnt_i + CW'(1);
      end else begin
        for (int i = 0; i < RECORD_DEPTH - 1; i++) begin
          win_o[i] = win_i[i+1];
        end
        win_o[RECORD_DEPTH-1] = push_val;
      end
    end
  end

  always_comb begin
    res_o.event_valid  = ev_valid;
    res_o.event_value  = ev_value;
    res_o.led_level    = stable_o;
    res_o.erase_first  = erase;
    res_o.write_offset = 12'(woff);
    res_o.record_count = 4'(cnt_o);
    res_o.record_bits  = 10'(win_o);
  end

endmodule

// ===== rtl/debounced_key_event_logger.sv =====
// top level of the debounced key event logger
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------
//  input   | in        | in_valid_i / in_ready_o   | in_data_i  (dkel_in_t)
//  result  | out       | out_valid_o / out_ready_i | out_data_o (dkel_out_t)
//
// one result per input item, one item per cycle sustained while out_ready_i is high
// each item passes the input register, then step logic into the result register
// state updates when an item leaves the input register, so back-to-back items chain
// a stalled result holds the result register and then the input register
// reset: history all ones, level released, window empty, log full, scan active
// no memory, so no clearing pass after reset
`include "debounced_key_event_logger_assert.svh"

module debounced_key_event_logger #(
  parameter int RECORD_DEPTH = 10,
  parameter int LOG_SIZE     = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dkel_pkg::dkel_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dkel_pkg::dkel_out_t out_data_o
);

  localparam int OW = $clog2(LOG_SIZE + 1);
  localparam int CW = $clog2(RECORD_DEPTH + 1);

  // input stage
  logic               s1_valid;
  dkel_pkg::dkel_in_t s1_data;
  logic               s1_take;
  logic               commit;

  // architectural state
  logic [7:0]              hist_q, hist_d;
  logic                    stable_q, stable_d;
  logic [RECORD_DEPTH-1:0] win_q, win_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [OW-1:0]           log_q, log_d;
  logic [OW-1:0]           pos_q, pos_d;
  logic                    scan_q, scan_d;

  // result register
  logic                out_valid_q, out_valid_d;
  dkel_pkg::dkel_out_t out_data_q;
  dkel_pkg::dkel_out_t res;

  // input register moves on whenever the result register is free or draining
  assign s1_take = !out_valid_q || out_ready_i;
  assign commit  = s1_valid && s1_take;

  dkel_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .take_i     (s1_take),
    .valid_o    (s1_valid),
    .data_o     (s1_data)
  );

  dkel_step #(
    .RECORD_DEPTH (RECORD_DEPTH),
    .LOG_SIZE     (LOG_SIZE)
  ) u_step (
    .item_i   (s1_data),
    .hist_i   (hist_q),
    .stable_i (stable_q),
    .win_i    (win_q),
    .cnt_i    (cnt_q),
    .log_i    (log_q),
    .pos_i    (pos_q),
    .scan_i   (scan_q),
    .hist_o   (hist_d),
    .stable_o (stable_d),
    .win_o    (win_d),
    .cnt_o    (cnt_d),
    .log_o    (log_d),
    .pos_o    (pos_d),
    .scan_o   (scan_d),
    .res_o    (res)
  );

  // result valid follows the input stage when it advances
  assign out_valid_d = s1_take ? s1_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q      <= dkel_pkg::HIST_ALL_HIGH;
      stable_q    <= 1'b1;
      win_q       <= '0;
      cnt_q       <= '0;
      log_q       <= OW'(LOG_SIZE);   // log treated as full until restored
      pos_q       <= '0;
      scan_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (commit) begin
        hist_q   <= hist_d;
        stable_q <= stable_d;
        win_q    <= win_d;
        cnt_q    <= cnt_d;
        log_q    <= log_d;
        pos_q    <= pos_d;
        scan_q   <= scan_d;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a confirmed press leaves the level low, a release leaves it high
  `DKEL_ASSERT_NOW(a_event_level, clk_i, rst_ni, out_valid_o && out_data_o.event_valid, out_data_o.event_value != out_data_o.led_level)
  // an erase always restarts the log at offset zero
  `DKEL_ASSERT_NOW(a_erase_offset, clk_i, rst_ni, out_valid_o && out_data_o.erase_first, out_data_o.event_valid && out_data_o.write_offset == 12'd0)
  // no event means the event fields read as zero
  `DKEL_ASSERT_NOW(a_idle_fields, clk_i, rst_ni, out_valid_o && !out_data_o.event_valid, !out_data_o.erase_first && !out_data_o.event_value && out_data_o.write_offset == 12'd0)
  // window fill never exceeds its depth
  `DKEL_ASSERT_NOW(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CW'(RECORD_DEPTH))
  // after an appended event the next free offset is past the start
  `DKEL_ASSERT_NEXT(a_log_advance, clk_i, rst_ni, commit && res.event_valid, log_q != '0 && !scan_q)

endmodule
